// ===== rtl/core/xdsu_pkg.sv =====
// Package for the XOR decoder signature unpacker.
// Holds the decoder stub pattern, its layout offsets and the result beat type.
// No dependencies.
package xdsu_pkg;

    localparam int STUB_LEN = 28;
    localparam int WIN_LEN  = 27;
    localparam int OFS_A    = 3;
    localparam int OFS_B    = 9;
    localparam int OFS_KEY  = 18;

    // Stub bytes; wildcard positions hold zero and are masked off
    localparam logic [7:0] STUB_VAL [STUB_LEN] = '{
        8'hEB, 8'h15, 8'hB9, 8'h00, 8'h00, 8'h00, 8'h00, 8'h81, 8'hF1, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h5E, 8'h80, 8'h74, 8'h31, 8'hFF, 8'h00, 8'hE2,
        8'hF9, 8'hEB, 8'h05, 8'hE8, 8'hE6, 8'hFF, 8'hFF, 8'hFF
    };

    localparam logic [7:0] STUB_MASK [STUB_LEN] = '{
        8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00,
        8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
    };

    // One result beat plus a flag saying whether the step produced one
    typedef struct packed {
        logic       present;
        logic [7:0] decoded_byte;
        logic       byte_valid;
        logic       message_end;
        logic       match_found;
    } res_t;

endpackage

// ===== rtl/core/xdsu_scan.sv =====
// Stub scanner and payload decoder: byte window, match compare, key and countdown.
// Depends on xdsu_pkg for the stub pattern and the result beat type.
module xdsu_scan
    import xdsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] byte_in,
    input  logic       last_in,
    output res_t       res
);

    logic [7:0]  window_reg [WIN_LEN];
    logic [4:0]  fill_reg;
    logic [4:0]  fill_next;
    logic        matched_reg;
    logic        matched_next;
    logic [7:0]  key_reg;
    logic [7:0]  key_next;
    logic [31:0] remaining_reg;
    logic [31:0] remaining_next;

    logic [7:0]  cand [STUB_LEN];
    logic        full;
    logic        hit;
    logic        new_match;
    logic        emit;
    logic [31:0] word_a;
    logic [31:0] word_b;

    // Candidate is the 27 stored bytes plus the incoming one
    always_comb
    begin
        for (int i = 0; i < WIN_LEN; i++)
        begin
            cand[i] = window_reg[i];
        end
        cand[WIN_LEN] = byte_in;
    end

    // Compare every stub position under its mask
    always_comb
    begin
        hit = 1'b1;
        for (int i = 0; i < STUB_LEN; i++)
        begin
            if ((cand[i] & STUB_MASK[i]) != STUB_VAL[i])
            begin
                hit = 1'b0;
            end
        end
    end

    assign word_a = {cand[OFS_A + 3], cand[OFS_A + 2], cand[OFS_A + 1], cand[OFS_A]};
    assign word_b = {cand[OFS_B + 3], cand[OFS_B + 2], cand[OFS_B + 1], cand[OFS_B]};

    assign full      = (fill_reg == 5'(WIN_LEN));
    assign new_match = !matched_reg && full && hit;
    assign emit      = matched_reg && (remaining_reg != 32'd0);

    // Build the result beat for this step
    always_comb
    begin
        res.present      = step && (emit || last_in);
        res.decoded_byte = emit ? (byte_in ^ key_reg) : 8'd0;
        res.byte_valid   = emit;
        res.message_end  = last_in;
        res.match_found  = matched_reg || new_match;
    end

    // Next control state; clear everything on the final byte
    always_comb
    begin
        fill_next      = fill_reg;
        matched_next   = matched_reg;
        key_next       = key_reg;
        remaining_next = remaining_reg;
        if (step)
        begin
            if (last_in)
            begin
                fill_next      = 5'd0;
                matched_next   = 1'b0;
                key_next       = 8'd0;
                remaining_next = 32'd0;
            end
            else
            begin
                if (!full)
                begin
                    fill_next = fill_reg + 5'd1;
                end
                if (new_match)
                begin
                    matched_next   = 1'b1;
                    key_next       = cand[OFS_KEY];
                    remaining_next = word_a ^ word_b;
                end
                else if (emit)
                begin
                    remaining_next = remaining_reg - 32'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= 5'd0;
            matched_reg   <= 1'b0;
            key_reg       <= 8'd0;
            remaining_reg <= 32'd0;
        end
        else
        begin
            fill_reg      <= fill_next;
            matched_reg   <= matched_next;
            key_reg       <= key_next;
            remaining_reg <= remaining_next;
        end
    end

    // Shift the window; the fill count gates the compare so contents need no reset
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            for (int i = 0; i < WIN_LEN - 1; i++)
            begin
                window_reg[i] <= window_reg[i + 1];
            end
            window_reg[WIN_LEN - 1] <= byte_in;
        end
    end

endmodule

// ===== rtl/core/xor_decoder_signature_unpacker_top.sv =====
// Top level of the XOR decoder signature unpacker: input register, scanner, result register.
// Depends on xdsu_pkg and xdsu_scan.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+--------------------------------------------------
//  input   | in_valid  | in_stall  | in_byte, in_last
//  output  | out_valid | out_stall | decoded_byte, byte_valid, message_end, match_found
//
// One byte per cycle sustained while the output is not stalled; each byte passes the input
// register and then its result, if any, passes the result register.
// The scanner's stub compare and countdown are worked combinationally between the two.
// Reset clears the fill count, match flag, key, countdown and both valid flags.
// A stall on the output while out_valid is high holds the result register and, with the
// input register full, raises in_stall in the same cycle.
module xor_decoder_signature_unpacker_top
    import xdsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] decoded_byte,
    output logic       byte_valid,
    output logic       message_end,
    output logic       match_found
);

    logic       in_full_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       res_valid_reg;
    logic [7:0] res_byte_reg;
    logic       res_bvalid_reg;
    logic       res_end_reg;
    logic       res_match_reg;

    logic       advance;
    logic       step;
    logic       in_take;
    res_t       res;

    assign advance  = !res_valid_reg || !out_stall;
    assign step     = in_full_reg && advance;
    assign in_stall = in_full_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // Hold the input beat until the scanner consumes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_full_reg <= 1'b1;
        end
        else if (step)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= in_byte;
            in_last_reg <= in_last;
        end
    end

    xdsu_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .byte_in (in_byte_reg),
        .last_in (in_last_reg),
        .res     (res)
    );

    // Advance the result register when empty or taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= res.present;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.present)
        begin
            res_byte_reg   <= res.decoded_byte;
            res_bvalid_reg <= res.byte_valid;
            res_end_reg    <= res.message_end;
            res_match_reg  <= res.match_found;
        end
    end

    assign out_valid    = res_valid_reg;
    assign decoded_byte = res_byte_reg;
    assign byte_valid   = res_bvalid_reg;
    assign message_end  = res_end_reg;
    assign match_found  = res_match_reg;

endmodule
